// File: rtl/core/lobm_pkg.sv
// Shared types and constants for the limit order book matcher.
// No dependencies; every other file of the block refers to this package.
package lobm_pkg;

  // Default book depth and the fixed field widths of the order and result items.
  localparam int BOOK_DEPTH_DEF = 64;
  localparam int QTY_W          = 16;
  localparam int PRICE_W        = 20;
  localparam int COUNT_W        = 7;

  // One resting order as a cell holds it.
  typedef struct packed {
    logic               side;
    logic [QTY_W-1:0]   qty;
    logic [PRICE_W-1:0] price;
  } entry_t;

  // Search token that walks the cell row, one cell per cycle.
  typedef struct packed {
    logic               v;
    logic               found;
    logic [QTY_W-1:0]   qty;
    logic [PRICE_W-1:0] price;
  } token_t;

  // Book update broadcast to all cells in a single cycle.
  typedef struct packed {
    logic               en;
    logic               remove;
    logic               match;
    logic               app;
    logic               side;
    logic [QTY_W-1:0]   dec_qty;
    logic [QTY_W-1:0]   rem_qty;
    logic [PRICE_W-1:0] price;
  } update_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_EMIT
  } state_t;

endpackage

// File: rtl/core/lobm_if.sv
// Valid/ready channel interfaces for incoming orders and for match results.
// Depends on lobm_pkg for the field widths.
interface lobm_in_if;
  logic                        valid;
  logic                        ready;
  logic                        side_buy;
  logic [lobm_pkg::QTY_W-1:0]   order_qty;
  logic [lobm_pkg::PRICE_W-1:0] order_price;

  modport source (output valid, side_buy, order_qty, order_price, input ready);
  modport sink   (input valid, side_buy, order_qty, order_price, output ready);
endinterface

interface lobm_out_if;
  logic                         valid;
  logic                         ready;
  logic                         matched;
  logic [lobm_pkg::QTY_W-1:0]   fill_qty;
  logic [lobm_pkg::PRICE_W-1:0] trade_price;
  logic                         rested;
  logic                         dropped_full;
  logic [lobm_pkg::COUNT_W-1:0] entry_count;

  modport source (output valid, matched, fill_qty, trade_price, rested, dropped_full,
                  entry_count, input ready);
  modport sink   (input valid, matched, fill_qty, trade_price, rested, dropped_full,
                  entry_count, output ready);
endinterface

// File: rtl/core/limit_order_book_match_top.sv
// Top level of the limit order book matcher: sequencer plus a row of book cells.
// Depends on lobm_pkg, lobm_if, lobm_cell and lobm_ctrl.
//
//   Channel  Direction  Handshake     Payload
//   in_ch    input      valid/ready   side_buy, order_qty, order_price
//   out_ch   output     valid/ready   matched, fill_qty, trade_price, rested,
//                                     dropped_full, entry_count
//
// For an order with nonzero quantity, the search token walks the cell row one cell
// per cycle; then the update is applied, the result register is loaded and the
// sequencer returns to idle before the next order is taken.
// An order of zero quantity skips the walk and the update.
// Reset clears the sequencer, the count and the token valids; the book starts empty.
// A result that waits in the output register does not stop the next order from
// being taken, but that order holds in its result cycle until the register is free.
module limit_order_book_match_top #(
  parameter int BOOK_DEPTH = lobm_pkg::BOOK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  lobm_in_if.sink    in_ch,
  lobm_out_if.source out_ch
);

  localparam int IDX_W = $clog2(BOOK_DEPTH);
  localparam int CNT_W = $clog2(BOOK_DEPTH + 1);

  lobm_pkg::token_t             tok  [BOOK_DEPTH+1];
  logic [IDX_W-1:0]             tidx [BOOK_DEPTH+1];
  lobm_pkg::entry_t             ent  [BOOK_DEPTH];
  lobm_pkg::entry_t             nbr  [BOOK_DEPTH];
  lobm_pkg::update_t            upd;
  logic [IDX_W-1:0]             upd_idx;
  logic [CNT_W-1:0]             upd_pos;
  logic [CNT_W-1:0]             count;
  logic                         ord_buy;
  logic [lobm_pkg::PRICE_W-1:0] ord_price;

  assign tidx[0] = '0;

  // Sequencer.
  lobm_ctrl #(
    .BOOK_DEPTH (BOOK_DEPTH),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .tok_o       (tok[0]),
    .count_o     (count),
    .ord_buy_o   (ord_buy),
    .ord_price_o (ord_price),
    .tail_tok_i  (tok[BOOK_DEPTH]),
    .tail_idx_i  (tidx[BOOK_DEPTH]),
    .upd_o       (upd),
    .upd_idx_o   (upd_idx),
    .upd_pos_o   (upd_pos)
  );

  // Row of cells; on a removal, each cell at or above the removed slot takes its upper neighbor.
  for (genvar i = 0; i < BOOK_DEPTH; i++) begin : g_cell
    if (i == BOOK_DEPTH - 1) begin : g_last
      assign nbr[i] = ent[i];
    end else begin : g_mid
      assign nbr[i] = ent[i+1];
    end

    lobm_cell #(
      .BOOK_DEPTH (BOOK_DEPTH),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W),
      .IDX        (i)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .count_i     (count),
      .ord_buy_i   (ord_buy),
      .ord_price_i (ord_price),
      .tok_i       (tok[i]),
      .tok_idx_i   (tidx[i]),
      .tok_o       (tok[i+1]),
      .tok_idx_o   (tidx[i+1]),
      .upd_i       (upd),
      .upd_idx_i   (upd_idx),
      .upd_pos_i   (upd_pos),
      .nbr_i       (nbr[i]),
      .ent_o       (ent[i])
    );
  end

endmodule

// File: rtl/core/lobm_cell.sv
// One book slot: holds a resting order, takes its turn in the search walk and
// applies the broadcast update. Depends on lobm_pkg.
module lobm_cell #(
  parameter int BOOK_DEPTH = lobm_pkg::BOOK_DEPTH_DEF,
  parameter int IDX_W      = $clog2(BOOK_DEPTH),
  parameter int CNT_W      = $clog2(BOOK_DEPTH + 1),
  parameter int IDX        = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [CNT_W-1:0]             count_i,
  input  logic                         ord_buy_i,
  input  logic [lobm_pkg::PRICE_W-1:0] ord_price_i,
  input  lobm_pkg::token_t             tok_i,
  input  logic [IDX_W-1:0]             tok_idx_i,
  output lobm_pkg::token_t             tok_o,
  output logic [IDX_W-1:0]             tok_idx_o,
  input  lobm_pkg::update_t            upd_i,
  input  logic [IDX_W-1:0]             upd_idx_i,
  input  logic [CNT_W-1:0]             upd_pos_i,
  input  lobm_pkg::entry_t             nbr_i,
  output lobm_pkg::entry_t             ent_o
);

  lobm_pkg::entry_t ent_r, ent_nxt;
  lobm_pkg::token_t tok_r, tok_nxt;
  logic [IDX_W-1:0] tidx_r, tidx_nxt;
  logic             live, crosses, better;

  // Search step: fold this slot into the best crossing order seen so far.
  always_comb begin
    live    = CNT_W'(IDX) < count_i;
    crosses = live && (ent_r.side != ord_buy_i) &&
              (ord_buy_i ? (ent_r.price <= ord_price_i) : (ent_r.price >= ord_price_i));
    better  = !tok_i.found ||
              (ord_buy_i ? (ent_r.price < tok_i.price) : (ent_r.price > tok_i.price));
    tok_nxt  = tok_i;
    tidx_nxt = tok_idx_i;
    if (crosses && better) begin
      tok_nxt.found = 1'b1;
      tok_nxt.qty   = ent_r.qty;
      tok_nxt.price = ent_r.price;
      tidx_nxt      = IDX_W'(IDX);
    end
  end

  // Update step: shift down past a removed order, reduce a partial fill, or append.
  always_comb begin
    ent_nxt = ent_r;
    if (upd_i.en) begin
      if (upd_i.remove && (IDX_W'(IDX) >= upd_idx_i)) begin
        ent_nxt = nbr_i;
      end else if (upd_i.match && (IDX_W'(IDX) == upd_idx_i)) begin
        ent_nxt.qty = ent_r.qty - upd_i.dec_qty;
      end
      if (upd_i.app && (CNT_W'(IDX) == upd_pos_i)) begin
        ent_nxt.side  = upd_i.side;
        ent_nxt.qty   = upd_i.rem_qty;
        ent_nxt.price = upd_i.price;
      end
    end
  end

  // The stored order needs no reset; the slot count says which slots are live.
  always_ff @(posedge clk) begin
    ent_r  <= ent_nxt;
    tidx_r <= tidx_nxt;
  end

  // Token register; only its valid flag is control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.v <= 1'b0;
    end else begin
      tok_r.v <= tok_nxt.v;
    end
    tok_r.found <= tok_nxt.found;
    tok_r.qty   <= tok_nxt.qty;
    tok_r.price <= tok_nxt.price;
  end

  assign tok_o     = tok_r;
  assign tok_idx_o = tidx_r;
  assign ent_o     = ent_r;

endmodule

// File: rtl/core/lobm_ctrl.sv
// Sequencer of the matcher: takes orders, launches the search walk, works out
// the trade and the book update, and holds the result register. Depends on
// lobm_pkg and the channel interfaces.
module lobm_ctrl #(
  parameter int BOOK_DEPTH = lobm_pkg::BOOK_DEPTH_DEF,
  parameter int IDX_W      = $clog2(BOOK_DEPTH),
  parameter int CNT_W      = $clog2(BOOK_DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  lobm_in_if.sink                      in_ch,
  lobm_out_if.source                   out_ch,
  output lobm_pkg::token_t             tok_o,
  output logic [CNT_W-1:0]             count_o,
  output logic                         ord_buy_o,
  output logic [lobm_pkg::PRICE_W-1:0] ord_price_o,
  input  lobm_pkg::token_t             tail_tok_i,
  input  logic [IDX_W-1:0]             tail_idx_i,
  output lobm_pkg::update_t            upd_o,
  output logic [IDX_W-1:0]             upd_idx_o,
  output logic [CNT_W-1:0]             upd_pos_o
);

  lobm_pkg::state_t state_r, state_nxt;

  logic                         first_r;
  logic [CNT_W-1:0]             count_r;
  logic                         ord_buy_r;
  logic [lobm_pkg::QTY_W-1:0]   ord_qty_r;
  logic [lobm_pkg::PRICE_W-1:0] ord_price_r;

  // Outcome of the search, kept for the update cycle and the result.
  logic                         m_r, remove_r, app_r, drop_r;
  logic [lobm_pkg::QTY_W-1:0]   tqty_r, rem_r;
  logic [lobm_pkg::PRICE_W-1:0] tprice_r;
  logic [IDX_W-1:0]             idx_r;
  logic [CNT_W-1:0]             cnt1_r;

  logic                         out_valid_r;
  logic                         out_matched_r, out_rested_r, out_dropped_r;
  logic [lobm_pkg::QTY_W-1:0]   out_tqty_r;
  logic [lobm_pkg::PRICE_W-1:0] out_tprice_r;
  logic [lobm_pkg::COUNT_W-1:0] out_count_r;

  logic                         accept, emit;
  logic [lobm_pkg::QTY_W-1:0]   cap_tq, cap_rem;
  logic                         cap_rm, cap_want, cap_app;
  logic [CNT_W-1:0]             cap_cnt1;

  assign accept = in_ch.valid && in_ch.ready;
  assign emit   = (state_r == lobm_pkg::S_EMIT) && !out_valid_r;

  // Trade arithmetic on the token that leaves the last cell.
  always_comb begin
    if (!tail_tok_i.found) begin
      cap_tq = '0;
    end else if (ord_qty_r < tail_tok_i.qty) begin
      cap_tq = ord_qty_r;
    end else begin
      cap_tq = tail_tok_i.qty;
    end
    cap_rm   = tail_tok_i.found && (tail_tok_i.qty == cap_tq);
    cap_cnt1 = count_r - CNT_W'(cap_rm);
    cap_rem  = ord_qty_r - cap_tq;
    cap_want = cap_rem != '0;
    cap_app  = cap_want && (cap_cnt1 < CNT_W'(BOOK_DEPTH));
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lobm_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = (in_ch.order_qty == '0) ? lobm_pkg::S_EMIT : lobm_pkg::S_SCAN;
        end
      end
      lobm_pkg::S_SCAN: begin
        if (tail_tok_i.v) begin
          state_nxt = lobm_pkg::S_APPLY;
        end
      end
      lobm_pkg::S_APPLY: begin
        state_nxt = lobm_pkg::S_EMIT;
      end
      lobm_pkg::S_EMIT: begin
        if (!out_valid_r) begin
          state_nxt = lobm_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = lobm_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs toward the channels and the cell row.
  always_comb begin
    in_ch.ready = (state_r == lobm_pkg::S_IDLE);

    tok_o       = '0;
    tok_o.v     = (state_r == lobm_pkg::S_SCAN) && first_r;

    upd_o.en      = (state_r == lobm_pkg::S_APPLY);
    upd_o.remove  = remove_r;
    upd_o.match   = m_r;
    upd_o.app     = app_r;
    upd_o.side    = ord_buy_r;
    upd_o.dec_qty = tqty_r;
    upd_o.rem_qty = rem_r;
    upd_o.price   = ord_price_r;
  end

  assign count_o     = count_r;
  assign ord_buy_o   = ord_buy_r;
  assign ord_price_o = ord_price_r;
  assign upd_idx_o   = idx_r;
  assign upd_pos_o   = cnt1_r;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.matched      = out_matched_r;
  assign out_ch.fill_qty     = out_tqty_r;
  assign out_ch.trade_price  = out_tprice_r;
  assign out_ch.rested       = out_rested_r;
  assign out_ch.dropped_full = out_dropped_r;
  assign out_ch.entry_count  = out_count_r;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lobm_pkg::S_IDLE;
      first_r     <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        first_r <= 1'b1;
      end else if (state_r == lobm_pkg::S_SCAN) begin
        first_r <= 1'b0;
      end
      if (state_r == lobm_pkg::S_APPLY) begin
        count_r <= cnt1_r + CNT_W'(app_r);
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Order capture, search outcome and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      ord_buy_r   <= in_ch.side_buy;
      ord_qty_r   <= in_ch.order_qty;
      ord_price_r <= in_ch.order_price;
      // An order of zero quantity leaves these cleared and skips the walk.
      m_r      <= 1'b0;
      tqty_r   <= '0;
      tprice_r <= '0;
      remove_r <= 1'b0;
      app_r    <= 1'b0;
      drop_r   <= 1'b0;
    end else if ((state_r == lobm_pkg::S_SCAN) && tail_tok_i.v) begin
      m_r      <= tail_tok_i.found;
      tqty_r   <= cap_tq;
      tprice_r <= tail_tok_i.found ? tail_tok_i.price : '0;
      remove_r <= cap_rm;
      idx_r    <= tail_idx_i;
      cnt1_r   <= cap_cnt1;
      rem_r    <= cap_rem;
      app_r    <= cap_app;
      drop_r   <= cap_want && !cap_app;
    end
    if (emit) begin
      out_matched_r <= m_r;
      out_tqty_r    <= tqty_r;
      out_tprice_r  <= tprice_r;
      out_rested_r  <= app_r;
      out_dropped_r <= drop_r;
      out_count_r   <= lobm_pkg::COUNT_W'(count_r);
    end
  end

endmodule

// File: rtl/core/lobm_checker.sv
// Port-level checks of the limit order book matcher, bound to the top level.
// Depends on lobm_pkg for the field widths.
module lobm_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_matched,
  input logic [lobm_pkg::QTY_W-1:0]   out_fill_qty,
  input logic [lobm_pkg::PRICE_W-1:0] out_trade_price,
  input logic                         out_rested,
  input logic                         out_dropped_full,
  input logic [lobm_pkg::COUNT_W-1:0] out_entry_count
);

  // A stalled result holds its value until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_matched) &&
    $stable(out_fill_qty) && $stable(out_trade_price) && $stable(out_rested) &&
    $stable(out_dropped_full) && $stable(out_entry_count))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Orders are worked one at a time: the block is busy right after taking one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("order taken while the previous one is in progress");

  // A result is never followed by another in the very next cycle.
  a_no_back_to_back_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid)
    else $error("second result right after a transaction");

endmodule

bind limit_order_book_match_top lobm_checker u_lobm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_matched      (out_ch.matched),
  .out_fill_qty     (out_ch.fill_qty),
  .out_trade_price  (out_ch.trade_price),
  .out_rested       (out_ch.rested),
  .out_dropped_full (out_ch.dropped_full),
  .out_entry_count  (out_ch.entry_count)
);
